### hdl/biquad_cascade_filter_macros.svh
// Assertion macros for the biquad cascade filter checker.
`ifndef BIQUAD_CASCADE_FILTER_MACROS_SVH
`define BIQUAD_CASCADE_FILTER_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define BQC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define BQC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/bqc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared constants, register codes, state encoding and control structs for
// the biquad cascade filter.
// ----------------------------------------------------------------------------
package bqc_pkg;

  localparam int MAX_SECTIONS = 5;
  localparam int CHANNELS     = 2;
  localparam int SAMPLE_WIDTH = 24;
  localparam int CH_W         = 1;
  localparam int COEF_W       = 24;
  localparam int COEF_FRAC    = 20;
  localparam int WORD_W       = 32;
  localparam int ACC_W        = 60;
  localparam int CNT_W        = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int WORD_COUNT   = CHANNELS * MAX_SECTIONS;
  localparam int IDX_W        = $clog2(WORD_COUNT);
  localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int EFF_W        = 4;
  localparam int BIT_W        = $clog2(COEF_W);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4,
    REG_COUNT = 3'd5
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FEEDBACK,
    ST_WNEW,
    ST_FEEDFWD,
    ST_YNEW,
    ST_DONE
  } bqc_state_t;

  // Coefficient set, raw Q4.20 bits
  typedef struct packed {
    logic [COEF_W-1:0] b0;
    logic [COEF_W-1:0] b1;
    logic [COEF_W-1:0] b2;
    logic [COEF_W-1:0] a1;
    logic [COEF_W-1:0] a2;
  } coef_set_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic             take;      // capture input word
    logic             load;      // fetch delay words, load coefficient shifters
    logic             step;      // one coefficient bit into the accumulator
    logic             first;     // current bit is the coefficient sign bit
    logic             feedback;  // feedback pass (a1, a2) vs feedforward pass
    logic             fin_w;     // round and store new w
    logic             fin_y;     // round and store section output, write delays
    logic             out_load;  // move result to output register
    logic [SEC_W-1:0] sec;       // current section
  } bqc_ctrl_t;

endpackage

### hdl/bqc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_in_if / bqc_out_if
// Valid/ready stream channels for input samples and filtered samples.
// ----------------------------------------------------------------------------
interface bqc_in_if;
  import bqc_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic        [CH_W-1:0]         channel;

  modport source (output valid, output sample_in, output channel, input ready);
  modport sink   (input valid, input sample_in, input channel, output ready);
endinterface

interface bqc_out_if;
  import bqc_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

### hdl/bqc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_mac
// Bit-serial multiply-accumulate datapath for one biquad section. Coefficients
// sit in shift registers and feed one bit per cycle, MSB first, into a Horner
// accumulator; rounding and 32-bit saturation close each pass.
// ----------------------------------------------------------------------------
module bqc_mac (
  input  logic                                     clk,
  input  bqc_pkg::bqc_ctrl_t                       ctrl,
  input  bqc_pkg::coef_set_t                       coef,
  input  logic signed [bqc_pkg::SAMPLE_WIDTH-1:0]  sample,
  input  logic signed [bqc_pkg::WORD_W-1:0]        w1_rd,
  input  logic signed [bqc_pkg::WORD_W-1:0]        w2_rd,
  output logic signed [bqc_pkg::WORD_W-1:0]        w1,
  output logic signed [bqc_pkg::WORD_W-1:0]        w,
  output logic signed [bqc_pkg::WORD_W-1:0]        x
);
  import bqc_pkg::*;

  localparam int TERM_W = WORD_W + 2;
  localparam int HI_LSB = COEF_FRAC + WORD_W - 1;

  logic signed [WORD_W-1:0] w2;
  logic signed [ACC_W-1:0]  acc;
  logic [COEF_W-1:0]        ca1, ca2, cb0, cb1, cb2;

  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  term_ext;
  logic signed [ACC_W-1:0]  acc_step;
  logic                     negate;
  logic signed [ACC_W-1:0]  bias;
  logic signed [ACC_W-1:0]  rsum;
  logic [ACC_W-HI_LSB-1:0]  rsum_hi;
  logic signed [WORD_W-1:0] rounded;

  // Partial term for the current coefficient bit
  always_comb begin
    if (ctrl.feedback) begin
      term = (ca1[COEF_W-1] ? TERM_W'(w1) : '0) + (ca2[COEF_W-1] ? TERM_W'(w2) : '0);
    end else begin
      term = (cb0[COEF_W-1] ? TERM_W'(w)  : '0) + (cb1[COEF_W-1] ? TERM_W'(w1) : '0)
           + (cb2[COEF_W-1] ? TERM_W'(w2) : '0);
    end
  end

  // Horner step: sign bit has negative weight, feedback terms are subtracted
  always_comb begin
    negate   = ctrl.feedback ^ ctrl.first;
    term_ext = ACC_W'(term);
    acc_step = negate ? (acc <<< 1) - term_ext : (acc <<< 1) + term_ext;
  end

  // Round half up and saturate; the w pass also adds x aligned to the product
  always_comb begin
    if (ctrl.fin_w) begin
      bias = {{(ACC_W-WORD_W-COEF_FRAC){x[WORD_W-1]}}, x, 1'b1, {(COEF_FRAC-1){1'b0}}};
    end else begin
      bias = {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
    end
    rsum    = acc + bias;
    rsum_hi = rsum[ACC_W-1:HI_LSB];
    if (&rsum_hi || ~|rsum_hi) begin
      rounded = rsum[HI_LSB:COEF_FRAC];
    end else if (rsum[ACC_W-1]) begin
      rounded = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      rounded = {1'b0, {(WORD_W-1){1'b1}}};
    end
  end

  // Operand, shifter and accumulator registers
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      x <= WORD_W'(sample);
    end
    if (ctrl.load) begin
      w1  <= w1_rd;
      w2  <= w2_rd;
      ca1 <= coef.a1;
      ca2 <= coef.a2;
      cb0 <= coef.b0;
      cb1 <= coef.b1;
      cb2 <= coef.b2;
      acc <= '0;
    end
    if (ctrl.step) begin
      acc <= acc_step;
      if (ctrl.feedback) begin
        ca1 <= ca1 << 1;
        ca2 <= ca2 << 1;
      end else begin
        cb0 <= cb0 << 1;
        cb1 <= cb1 << 1;
        cb2 <= cb2 << 1;
      end
    end
    if (ctrl.fin_w) begin
      w   <= rounded;
      acc <= '0;
    end
    if (ctrl.fin_y) begin
      x <= rounded;
    end
  end

endmodule

### hdl/bqc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_seq
// Sequencer: walks each section through a feedback pass and a feedforward
// pass of one coefficient bit per cycle, then hands the word to the output.
// ----------------------------------------------------------------------------
module bqc_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        out_free,
  input  logic [bqc_pkg::CNT_W-1:0]   section_count,
  output logic                        in_ready,
  output bqc_pkg::bqc_ctrl_t          ctrl
);
  import bqc_pkg::*;

  bqc_state_t       state, state_next;
  logic [BIT_W-1:0] bit_cnt;
  logic [SEC_W-1:0] sec;
  logic [EFF_W-1:0] eff;
  logic             last_bit;
  logic             last_sec;

  // Effective section count: zero runs one, large values clamp
  always_comb begin
    if (section_count == '0) begin
      eff = EFF_W'(1);
    end else if (EFF_W'(section_count) > EFF_W'(MAX_SECTIONS)) begin
      eff = EFF_W'(MAX_SECTIONS);
    end else begin
      eff = EFF_W'(section_count);
    end
    last_sec = (EFF_W'(sec) + EFF_W'(1)) == eff;
    last_bit = bit_cnt == BIT_W'(COEF_W - 1);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_LOAD;
      ST_LOAD:     state_next = ST_FEEDBACK;
      ST_FEEDBACK: if (last_bit) state_next = ST_WNEW;
      ST_WNEW:     state_next = ST_FEEDFWD;
      ST_FEEDFWD:  if (last_bit) state_next = ST_YNEW;
      ST_YNEW:     state_next = last_sec ? ST_DONE : ST_LOAD;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl     = '0;
    ctrl.sec = sec;
    ctrl.first = bit_cnt == '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.take = in_valid;
      end
      ST_LOAD:     ctrl.load = 1'b1;
      ST_FEEDBACK: begin
        ctrl.step     = 1'b1;
        ctrl.feedback = 1'b1;
      end
      ST_WNEW:     ctrl.fin_w = 1'b1;
      ST_FEEDFWD:  ctrl.step = 1'b1;
      ST_YNEW:     ctrl.fin_y = 1'b1;
      ST_DONE:     ctrl.out_load = out_free;
      default:     ctrl.out_load = 1'b0;
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= '0;
      sec     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_FEEDBACK || state == ST_FEEDFWD) begin
        bit_cnt <= last_bit ? '0 : bit_cnt + BIT_W'(1);
      end
      if (state == ST_IDLE) begin
        sec <= '0;
      end else if (state == ST_YNEW && !last_sec) begin
        sec <= sec + SEC_W'(1);
      end
    end
  end

endmodule

### hdl/biquad_cascade_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_cascade_filter
// Cascade of up to five direct form II biquads with shared coefficients and
// per-channel delay words, computed with bit-serial multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage:
//   din carries a Q1.23 sample and a channel number; dout returns the filtered
//   sample saturated to 24 bits, one word out for each word in.
//   Coefficients and the section count are written on cfg_we/cfg_index/
//   cfg_data while no sample is in flight; unknown indexes are ignored.
// Timing:
//   Each section runs a delay fetch, one feedback bit step per coefficient
//   bit, a rounding step, one feedforward bit step per coefficient bit, and
//   a rounding and write-back step; the bit steps follow the coefficient
//   width of the serial multiplier. The result is in the output register as
//   the sequencer returns to idle, and din is ready again in the same cycle;
//   no new sample is taken while one is in flight.
// Reset:
//   Synchronous rst restores the default coefficients (pass-through, one
//   section) and clears all delay words at once.
// Backpressure:
//   A finished word waits in the output register while a new sample is
//   taken; if it is still not taken when the next one finishes, the
//   sequencer holds until dout.ready.
// ----------------------------------------------------------------------------
module biquad_cascade_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bqc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bqc_pkg::CFG_DATA_W-1:0]    cfg_data,
  bqc_in_if.sink                            din,
  bqc_out_if.source                         dout
);
  import bqc_pkg::*;

  coef_set_t                coef;
  logic [CNT_W-1:0]         section_count;
  logic [CH_W-1:0]          ch;
  logic [WORD_W-1:0]        dly1 [WORD_COUNT];
  logic [WORD_W-1:0]        dly2 [WORD_COUNT];
  logic [IDX_W-1:0]         idx;
  logic signed [WORD_W-1:0] w1_rd, w2_rd;
  logic signed [WORD_W-1:0] w1, w, x;
  logic                     out_valid;
  logic [SAMPLE_WIDTH-1:0]  out_data;
  logic [SAMPLE_WIDTH-1:0]  out_sat;
  logic                     out_free;
  logic                     in_ready;
  bqc_ctrl_t                ctrl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0       <= COEF_W'(1 << COEF_FRAC);
      coef.b1       <= '0;
      coef.b2       <= '0;
      coef.a1       <= '0;
      coef.a2       <= '0;
      section_count <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_B0:    coef.b0 <= cfg_data[COEF_W-1:0];
        REG_B1:    coef.b1 <= cfg_data[COEF_W-1:0];
        REG_B2:    coef.b2 <= cfg_data[COEF_W-1:0];
        REG_A1:    coef.a1 <= cfg_data[COEF_W-1:0];
        REG_A2:    coef.a2 <= cfg_data[COEF_W-1:0];
        REG_COUNT: section_count <= cfg_data[CNT_W-1:0];
        default:   section_count <= section_count;
      endcase
    end
  end

  // Channel of the word in flight
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      ch <= din.channel;
    end
  end

  // Delay store, one word pair per channel and section
  always_comb begin
    idx   = IDX_W'(ch) * IDX_W'(MAX_SECTIONS) + IDX_W'(ctrl.sec);
    w1_rd = dly1[idx];
    w2_rd = dly2[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WORD_COUNT; i++) begin
        dly1[i] <= '0;
        dly2[i] <= '0;
      end
    end else if (ctrl.fin_y) begin
      dly1[idx] <= w;
      dly2[idx] <= w1;
    end
  end

  bqc_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (din.valid),
    .out_free      (out_free),
    .section_count (section_count),
    .in_ready      (in_ready),
    .ctrl          (ctrl)
  );

  bqc_mac u_mac (
    .clk    (clk),
    .ctrl   (ctrl),
    .coef   (coef),
    .sample (din.sample_in),
    .w1_rd  (w1_rd),
    .w2_rd  (w2_rd),
    .w1     (w1),
    .w      (w),
    .x      (x)
  );

  // Saturate the cascade output to the sample range
  always_comb begin
    if (&x[WORD_W-1:SAMPLE_WIDTH-1] || ~|x[WORD_W-1:SAMPLE_WIDTH-1]) begin
      out_sat = x[SAMPLE_WIDTH-1:0];
    end else if (x[WORD_W-1]) begin
      out_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      out_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  // Output register
  assign out_free = !out_valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_data <= out_sat;
    end
  end

  assign din.ready       = in_ready;
  assign dout.valid      = out_valid;
  assign dout.sample_out = out_data;

endmodule

### hdl/bqc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqc_checker
// Port-level checks on the biquad cascade filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "biquad_cascade_filter_macros.svh"

module bqc_checker (
  input logic       clk,
  input logic       rst,
  bqc_in_if.sink    din,
  bqc_out_if.source dout
);

  // Output register comes up empty after reset
  `BQC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !dout.valid, "output valid after reset")

  // A stalled word holds
  `BQC_ASSERT(a_out_hold, clk, rst, dout.valid && !dout.ready |=> dout.valid && $stable(dout.sample_out), "stalled output word changed")

  // Block is busy right after taking a word
  `BQC_ASSERT(a_busy_after_take, clk, rst, din.valid && din.ready |=> !din.ready, "input ready right after accept")

  // A new result appears only as the sequencer returns to idle
  `BQC_ASSERT(a_result_at_idle, clk, rst, $rose(dout.valid) |-> din.ready, "result appeared while busy")

endmodule

bind biquad_cascade_filter bqc_checker u_bqc_checker (
  .clk  (clk),
  .rst  (rst),
  .din  (din),
  .dout (dout)
);

### tb/tb_biquad_cascade_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_biquad_cascade_filter
// Self-checking bench for the cascaded biquad filter. A fixed-point model of
// the direct form II cascade runs beside the block and predicts each output
// word. Directed tests cover reset defaults, section count limits, unknown
// register writes, saturation and output backpressure. A long random run then
// sweeps coefficient sets and idle patterns on both stream ports.
// ----------------------------------------------------------------------------
module tb_biquad_cascade_filter;
  import bqc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 10;
  localparam int SETTLE_CYCLES = 51 * MAX_SECTIONS + 2 + 40;
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 700;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 24'sh800000;
  localparam logic [CFG_DATA_W-1:0] COEF_MAX = 24'h7FFFFF;
  localparam logic [CFG_DATA_W-1:0] COEF_MIN = 24'h800000;
  localparam logic [CFG_DATA_W-1:0] COEF_ONE = 24'h100000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bqc_in_if  din_if();
  bqc_out_if dout_if();

  biquad_cascade_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_if),
    .dout      (dout_if)
  );

  // Filter model state: coefficients, section setting and delay words
  logic signed [COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [CNT_W-1:0]         section_setting;
  longint                   delay1_mem [WORD_COUNT];
  longint                   delay2_mem [WORD_COUNT];

  logic signed [SAMPLE_WIDTH-1:0] filtered_q [$];
  logic signed [SAMPLE_WIDTH-1:0] expected_word;

  int error_count;
  int stall_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_left;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Fixed-point model
  // --------------------------------------------------------------------------
  function automatic longint round_q20(input longint v);
    return (v + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  function automatic longint clamp_signed(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void clear_filter_model();
    coef_b0         = COEF_ONE;
    coef_b1         = '0;
    coef_b2         = '0;
    coef_a1         = '0;
    coef_a2         = '0;
    section_setting = 3'd1;
    for (int i = 0; i < WORD_COUNT; i++) begin
      delay1_mem[i] = 0;
      delay2_mem[i] = 0;
    end
  endfunction

  // Runs one sample through the cascade and updates the delay words
  function automatic logic signed [SAMPLE_WIDTH-1:0] filter_sample(
      input logic signed [SAMPLE_WIDTH-1:0] s, input logic [CH_W-1:0] ch);
    longint x, w1, w2, w, acc;
    int     n, idx;
    x = s;
    n = section_setting;
    if (n == 0) n = 1;
    if (n > MAX_SECTIONS) n = MAX_SECTIONS;
    for (int k = 0; k < n; k++) begin
      idx = (int'(ch) % CHANNELS) * MAX_SECTIONS + k;
      w1  = delay1_mem[idx];
      w2  = delay2_mem[idx];
      acc = (x <<< COEF_FRAC) - longint'(coef_a1) * w1 - longint'(coef_a2) * w2;
      w   = clamp_signed(round_q20(acc), WORD_W);
      acc = longint'(coef_b0) * w + longint'(coef_b1) * w1 + longint'(coef_b2) * w2;
      x   = clamp_signed(round_q20(acc), WORD_W);
      delay2_mem[idx] = w1;
      delay1_mem[idx] = w;
    end
    return SAMPLE_WIDTH'(clamp_signed(x, SAMPLE_WIDTH));
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      REG_B0:    coef_b0 = value;
      REG_B1:    coef_b1 = value;
      REG_B2:    coef_b2 = value;
      REG_A1:    coef_a1 = value;
      REG_A2:    coef_a2 = value;
      REG_COUNT: section_setting = value[CNT_W-1:0];
      default:   ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one word on din, with random idle cycles first
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s,
                             input logic [CH_W-1:0] ch);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      din_if.valid <= 1'b0;
      @(negedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.sample_in <= s;
    din_if.channel   <= ch;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    filtered_q.push_back(filter_sample(s, ch));
  endtask

  // Stops offering and waits until every predicted word has come out
  task automatic wait_drained();
    @(negedge clk);
    din_if.valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
    case ($urandom_range(3))
      0:       return SAMPLE_WIDTH'(int'($urandom_range(0, 131071)) - 65536);
      1:       return SAMPLE_WIDTH'(int'($urandom_range(0, 4194303)) - 2097152);
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // New coefficient set: mostly stable filters, sometimes anything at all
  task automatic program_random_filter();
    int a2v, lim, a1v;
    if ($urandom_range(3) == 0) begin
      write_reg(REG_B0, CFG_DATA_W'($urandom));
      write_reg(REG_B1, CFG_DATA_W'($urandom));
      write_reg(REG_B2, CFG_DATA_W'($urandom));
      write_reg(REG_A1, CFG_DATA_W'($urandom));
      write_reg(REG_A2, CFG_DATA_W'($urandom));
      write_reg(REG_COUNT, CFG_DATA_W'($urandom));
    end else begin
      // a2 within +-0.9, |a1| below 0.9 * (1 + a2)
      a2v = int'($urandom_range(0, 1887436)) - 943718;
      lim = ((1048576 + a2v) / 10) * 9;
      a1v = int'($urandom_range(0, 2 * lim)) - lim;
      write_reg(REG_B0, CFG_DATA_W'(int'($urandom_range(0, 2097152)) - 1048576));
      write_reg(REG_B1, CFG_DATA_W'(int'($urandom_range(0, 2097152)) - 1048576));
      write_reg(REG_B2, CFG_DATA_W'(int'($urandom_range(0, 2097152)) - 1048576));
      write_reg(REG_A1, CFG_DATA_W'(a1v));
      write_reg(REG_A2, CFG_DATA_W'(a2v));
      write_reg(REG_COUNT, CFG_DATA_W'($urandom_range(0, 7)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, or a long hold when one is requested
  // --------------------------------------------------------------------------
  initial begin
    dout_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_left > 0) begin
        dout_if.ready  <= 1'b0;
        recv_hold_left  = recv_hold_left - 1;
      end else begin
        dout_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Output check against the oldest predicted word
  always @(posedge clk) begin
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected output word, actual %0d", $time, dout_if.sample_out);
        error_count++;
      end else begin
        expected_word = filtered_q.pop_front();
        if (dout_if.sample_out !== expected_word) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                   $time, expected_word, dout_if.sample_out);
          error_count++;
        end
      end
    end
  end

  // Cycles without any word moving on either port
  always @(posedge clk) begin
    if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("[biquad_cascade_filter] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset defaults: one section with b0 = 1.0 passes samples through
  task automatic test_reset_passthrough();
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(24'sh000000, 1'b0);
    send_sample(-24'sd1, 1'b1);
    send_sample(24'sd1, 1'b0);
    send_sample(24'sh555555, 1'b1);
    send_sample(24'shAAAAAA, 1'b0);
  endtask

  // Count 0 runs one section, count above the maximum runs all of them,
  // writes to unused indexes change nothing
  task automatic test_section_count_limits();
    wait_drained();
    write_reg(REG_B0, 24'h040000);
    write_reg(REG_B1, 24'h080000);
    write_reg(REG_B2, 24'h040000);
    write_reg(REG_A1, CFG_DATA_W'(-524288));
    write_reg(REG_A2, 24'h040000);
    write_reg(REG_SPARE6, 24'hFFFFFF);
    write_reg(REG_SPARE7, 24'h000000);
    write_reg(REG_COUNT, 24'd0);
    send_sample(24'sh400000, 1'b0);
    send_sample(24'sh400000, 1'b0);
    send_sample(-24'sd300000, 1'b1);
    wait_drained();
    write_reg(REG_COUNT, 24'd7);
    send_sample(24'sh400000, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(24'sh123456, 1'b0);
  endtask

  // Extreme coefficients drive the section sums and the output into saturation
  task automatic test_saturation_extremes();
    wait_drained();
    write_reg(REG_B0, COEF_MAX);
    write_reg(REG_B1, COEF_MIN);
    write_reg(REG_B2, COEF_MAX);
    write_reg(REG_A1, COEF_MIN);
    write_reg(REG_A2, COEF_MAX);
    write_reg(REG_COUNT, 24'd5);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    wait_drained();
    write_reg(REG_B0, COEF_MIN);
    write_reg(REG_COUNT, 24'd1);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1);
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    wait_drained();
    write_reg(REG_COUNT, 24'd1);
    write_reg(REG_B0, COEF_ONE);
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    recv_hold_left = HOLD_CYCLES;
    repeat (6) send_sample(random_sample(), CH_W'($urandom));
    // sender pauses until every word is out
    wait_drained();
  endtask

  // Random coefficient sets under the three idle patterns
  task automatic test_random_filters(input int total);
    int blocks, per_block;
    blocks    = 11;
    per_block = total / blocks;
    for (int b = 0; b < blocks; b++) begin
      if (b < 4) begin
        send_idle_pct = 31;
        recv_idle_pct = 48;
      end else if (b < 8) begin
        send_idle_pct = 48;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      program_random_filter();
      repeat (per_block) send_sample(random_sample(), CH_W'($urandom));
    end
  endtask

  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    din_if.valid     = 1'b0;
    din_if.sample_in = '0;
    din_if.channel   = '0;
    error_count      = 0;
    stall_cycles     = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    recv_hold_left   = 0;
    clear_filter_model();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_passthrough();
    test_section_count_limits();
    test_saturation_extremes();
    test_output_backpressure();
    test_random_filters(1100);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("[biquad_cascade_filter] OK");
    else
      $display("[biquad_cascade_filter] ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/bqc_pkg.sv
hdl/bqc_if.sv
hdl/bqc_mac.sv
hdl/bqc_seq.sv
hdl/biquad_cascade_filter.sv
hdl/bqc_checker.sv
tb/tb_biquad_cascade_filter.sv
